@@ rtl/core/xs128_pkg.sv @@
// ----------------------------------------------------------------------------
// xs128_pkg
// Shared constants, codes and control types for the xorshift128 generator.
// ----------------------------------------------------------------------------
package xs128_pkg;

    localparam int WORD_W     = 32;
    localparam int FRAC_W     = 24;
    localparam int NUM_WORDS  = 4;
    localparam int IDX_W      = $clog2(NUM_WORDS);
    localparam int FRAC_SHIFT = WORD_W - FRAC_W;

    localparam int S_DATA_W   = 32;
    localparam int S_USER_W   = 1;
    localparam int M_DATA_W   = 56;

    localparam logic [WORD_W-1:0] GOLDEN_STEP = 32'h9E37_79B9;
    localparam logic [WORD_W-1:0] MIX_MUL_A   = 32'h85EB_CA6B;
    localparam logic [WORD_W-1:0] MIX_MUL_B   = 32'hC2B2_AE35;

    // Item kinds carried in tuser
    localparam logic OP_DRAW   = 1'b0;
    localparam logic OP_RESEED = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic             seed_load;  // load running word from seed plus step
        logic             seed_zero;  // use zero instead of the input seed
        logic             mix_a;      // first avalanche multiply
        logic             mix_b;      // second avalanche multiply
        logic             store;      // finish the word and write it back
        logic             draw;       // shift the generator, capture result
        logic [IDX_W-1:0] word_idx;   // word being seeded
    } xs128_cmd_t;

endpackage

@@ rtl/core/xs128_ctrl.sv @@
// ----------------------------------------------------------------------------
// xs128_ctrl
// Controller: accepts beats, sequences the seeding pass, tracks the result.
// ----------------------------------------------------------------------------
module xs128_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic                 s_op,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output xs128_pkg::xs128_cmd_t cmd
);
    import xs128_pkg::*;

    localparam logic [2:0] ST_BOOT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MIXA  = 3'd2;
    localparam logic [2:0] ST_MIXB  = 3'd3;
    localparam logic [2:0] ST_STORE = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        cmd.word_idx   = idx_reg;

        if (m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_BOOT: begin
                cmd.seed_load = 1'b1;
                cmd.seed_zero = 1'b1;
                idx_next      = '0;
                state_next    = ST_MIXA;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (s_op == OP_RESEED) begin
                        cmd.seed_load = 1'b1;
                        idx_next      = '0;
                        state_next    = ST_MIXA;
                    end else begin
                        cmd.draw       = 1'b1;
                        out_valid_next = 1'b1;
                    end
                end
            end
            ST_MIXA: begin
                cmd.mix_a  = 1'b1;
                state_next = ST_MIXB;
            end
            ST_MIXB: begin
                cmd.mix_b  = 1'b1;
                state_next = ST_STORE;
            end
            ST_STORE: begin
                cmd.store = 1'b1;
                if (idx_reg == IDX_W'(NUM_WORDS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MIXA;
                end
            end
            default: begin
                state_next = ST_BOOT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_BOOT;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

@@ rtl/core/xs128_datapath.sv @@
// ----------------------------------------------------------------------------
// xs128_datapath
// Generator words, seed mixer with registered multiplies, result register.
// ----------------------------------------------------------------------------
module xs128_datapath (
    input  logic                           aclk,
    input  xs128_pkg::xs128_cmd_t          cmd,
    input  logic [xs128_pkg::WORD_W-1:0]   seed,
    output logic [xs128_pkg::WORD_W-1:0]   value,
    output logic [xs128_pkg::FRAC_W-1:0]   fraction
);
    import xs128_pkg::*;

    logic [WORD_W-1:0]   gen_reg [NUM_WORDS];
    logic [WORD_W-1:0]   run_reg;
    logic [WORD_W-1:0]   mix_reg;
    logic [WORD_W-1:0]   value_reg;
    logic [WORD_W-1:0]   seed_sel;
    logic [WORD_W-1:0]   mix_a_in, mix_b_in, mix_out;
    logic [2*WORD_W-1:0] prod_a, prod_b;
    logic [WORD_W-1:0]   t0, t1, t2, draw_word;

    assign seed_sel = cmd.seed_zero ? '0 : seed;

    assign mix_a_in = run_reg ^ (run_reg >> 16);
    assign prod_a   = mix_a_in * MIX_MUL_A;
    assign mix_b_in = mix_reg ^ (mix_reg >> 13);
    assign prod_b   = mix_b_in * MIX_MUL_B;
    assign mix_out  = mix_reg ^ (mix_reg >> 16);

    // One xorshift128 step
    assign t0        = gen_reg[NUM_WORDS-1];
    assign t1        = t0 ^ (t0 << 11);
    assign t2        = t1 ^ (t1 >> 8);
    assign draw_word = t2 ^ gen_reg[0] ^ (gen_reg[0] >> 19);

    always_ff @(posedge aclk) begin
        if (cmd.seed_load) begin
            run_reg <= seed_sel + GOLDEN_STEP;
        end else if (cmd.store) begin
            run_reg <= run_reg + GOLDEN_STEP;
        end

        if (cmd.mix_a) begin
            mix_reg <= prod_a[WORD_W-1:0];
        end else if (cmd.mix_b) begin
            mix_reg <= prod_b[WORD_W-1:0];
        end

        if (cmd.store) begin
            gen_reg[cmd.word_idx] <= mix_out;
        end else if (cmd.draw) begin
            for (int i = NUM_WORDS - 1; i > 0; i--) begin
                gen_reg[i] <= gen_reg[i-1];
            end
            gen_reg[0] <= draw_word;
            value_reg  <= draw_word;
        end
    end

    assign value    = value_reg;
    assign fraction = value_reg[WORD_W-1:FRAC_SHIFT];

endmodule

@@ rtl/core/xorshift128_generator_top.sv @@
// ----------------------------------------------------------------------------
// xorshift128_generator_top
// Xorshift128 random generator with SplitMix32-style seed expansion.
// ----------------------------------------------------------------------------
//  Channel  Direction  tdata (low bit up)                tuser
//  s_       in         [31:0] seed                       [0] op (0 draw, 1 reseed)
//  m_       out        [31:0] value, [55:32] fraction    -
//
//  The result of a draw beat lands in the output register the cycle after
//  acceptance.
//  A reseed beat is accepted, then for each of the 4 state words the block
//  runs two registered 32x32 multiplies and a store.
//  After reset the block seeds itself from zero by the same steps with
//  s_tready low. A stalled result blocks only the next beat; the output
//  register frees as soon as m_tready takes it.
// ----------------------------------------------------------------------------
module xorshift128_generator_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [xs128_pkg::S_DATA_W-1:0]  s_tdata,  // [31:0] seed
    input  logic [xs128_pkg::S_USER_W-1:0]  s_tuser,  // [0] op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [xs128_pkg::M_DATA_W-1:0]  m_tdata   // [31:0] value, [55:32] fraction
);
    import xs128_pkg::*;

    xs128_cmd_t        cmd;
    logic [WORD_W-1:0] value;
    logic [FRAC_W-1:0] fraction;

    // Sequence acceptance, seeding and the result handshake
    xs128_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser[0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Hold the generator words and compute draws and seed words
    xs128_datapath u_datapath (
        .aclk     (aclk),
        .cmd      (cmd),
        .seed     (s_tdata[WORD_W-1:0]),
        .value    (value),
        .fraction (fraction)
    );

    // Pack the result beat: value in the low bits, fraction above it
    assign m_tdata = {fraction, value};

    // Busy while seeding: no beat is taken outside idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == OP_RESEED) |=> !s_tready)
        else $error("beat accepted during seeding");

    // An accepted draw always yields a result in the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == OP_DRAW) |=> m_tvalid)
        else $error("draw produced no result");

    // Fraction is the top bits of value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[WORD_W+FRAC_W-1:WORD_W] == m_tdata[WORD_W-1:FRAC_SHIFT]))
        else $error("fraction does not match value");

endmodule

@@ tb/xorshift128_draw_checker.sv @@
// ----------------------------------------------------------------------------
// xorshift128_draw_checker
// Watches both stream channels of the xorshift128 generator. Keeps its own
// copy of the four state words, predicts every draw from the accepted input
// beats, and compares each result beat with the oldest predicted draw.
// ----------------------------------------------------------------------------
module xorshift128_draw_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [xs128_pkg::S_DATA_W-1:0] s_tdata,   // [31:0] seed
    input  logic [xs128_pkg::S_USER_W-1:0] s_tuser,   // [0] op
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [xs128_pkg::M_DATA_W-1:0] m_tdata,   // [31:0] value, [55:32] fraction
    output int                             mismatch_count,
    output int                             draws_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import xs128_pkg::*;

    // Same layout as m_tdata: value in the low word, fraction above it.
    typedef struct packed {
        logic [FRAC_W-1:0] fraction;
        logic [WORD_W-1:0] value;
    } draw_t;

    logic [WORD_W-1:0] gen_word [NUM_WORDS];
    draw_t             awaited_draws [$];

    initial begin
        mismatch_count    = 0;
        draws_outstanding = 0;
    end

    function automatic logic [WORD_W-1:0] avalanche_mix(input logic [WORD_W-1:0] z);
        z = (z ^ (z >> 16)) * MIX_MUL_A;
        z = (z ^ (z >> 13)) * MIX_MUL_B;
        return z ^ (z >> 16);
    endfunction

    function automatic void seed_state(input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] run;
        run = seed;
        for (int k = 0; k < NUM_WORDS; k++) begin
            run         = run + GOLDEN_STEP;
            gen_word[k] = avalanche_mix(run);
        end
    endfunction

    function automatic logic [WORD_W-1:0] advance_state();
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] v;
        t           = gen_word[3];
        v           = gen_word[0];
        gen_word[3] = gen_word[2];
        gen_word[2] = gen_word[1];
        gen_word[1] = v;
        t           = t ^ (t << 11);
        t           = t ^ (t >> 8);
        gen_word[0] = t ^ v ^ (v >> 19);
        return gen_word[0];
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatch_count++;
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    always @(posedge aclk) begin : watch_channels
        draw_t got;
        draw_t want;
        if (!aresetn) begin
            seed_state('0);
            awaited_draws.delete();
        end else begin
            // Check the result beat first: it always belongs to an earlier input beat.
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (awaited_draws.size() == 0) begin
                    report_mismatch("unexpected result beat", got.value, '0);
                end else begin
                    want = awaited_draws.pop_front();
                    if (got.value !== want.value) begin
                        report_mismatch("value", got.value, want.value);
                    end
                    if (got.fraction !== want.fraction) begin
                        report_mismatch("fraction", WORD_W'(got.fraction), WORD_W'(want.fraction));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser[0] == OP_RESEED) begin
                    seed_state(s_tdata);
                end else begin
                    want.value    = advance_state();
                    want.fraction = want.value[WORD_W-1 -: FRAC_W];
                    awaited_draws.push_back(want);
                end
            end
        end
        draws_outstanding = awaited_draws.size();
    end

endmodule

@@ tb/xorshift128_generator_top_tb.sv @@
// ----------------------------------------------------------------------------
// xorshift128_generator_top_tb
// Drives draw and reseed beats into the xorshift128 generator under several
// idling mixes and one long receiver hold-off; a separate checker predicts
// every draw and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module xorshift128_generator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import xs128_pkg::*;

    // Set well above the slowest correct run.
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int PHASE_BEATS   = 105;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;    // covers a trailing reseed

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;   // [31:0] seed
    logic [S_USER_W-1:0] s_tuser  = '0;   // [0] op
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;         // [31:0] value, [55:32] fraction

    int mismatch_count;
    int draws_outstanding;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_request   = 1'b0;

    // 8 ns clock period.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    xorshift128_generator_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    xorshift128_draw_checker draw_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .s_tuser           (s_tuser),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata),
        .mismatch_count    (mismatch_count),
        .draws_outstanding (draws_outstanding)
    );

    // Guard against a hang: end the run as a failure past the limit.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: hold off for a long stretch on request, otherwise stall at
    // the current rate. One assignment to m_tready per edge.
    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one beat and wait for its handshake. Called right after a rising
    // edge; idle cycles go in front of the beat at the current sender rate.
    task automatic send_beat(input logic op, input logic [S_DATA_W-1:0] seed);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= seed;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
    endtask

    // Mostly draws with a random (ignored) seed field, now and then a reseed.
    task automatic send_random_beats(input int count);
        repeat (count) begin
            if ($urandom_range(7) == 0) begin
                send_beat(OP_RESEED, $urandom());
            end else begin
                send_beat(OP_DRAW, $urandom());
            end
        end
    endtask

    initial begin
        // Hold reset, then release once.
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: draws from the power-on seed of zero, with the seed field
        // at both extremes to show it is ignored on a draw.
        send_beat(OP_DRAW, '0);
        send_beat(OP_DRAW, '1);
        send_beat(OP_DRAW, 32'hAAAA_AAAA);
        send_beat(OP_DRAW, 32'h5555_5555);
        // Reseed at the seed extremes, each followed by draws.
        send_beat(OP_RESEED, '0);
        send_beat(OP_DRAW, '0);
        send_beat(OP_DRAW, '0);
        send_beat(OP_RESEED, '1);
        send_beat(OP_DRAW, '1);
        send_beat(OP_DRAW, '1);
        // Seed whose first golden-ratio step wraps the running word to zero.
        send_beat(OP_RESEED, 32'h61C8_8647);
        send_beat(OP_DRAW, 32'h0000_0001);
        // Back-to-back reseeds: only the last one must stick.
        send_beat(OP_RESEED, 32'h8000_0000);
        send_beat(OP_RESEED, 32'h0000_0001);
        send_beat(OP_RESEED, 32'h1234_5678);
        send_beat(OP_DRAW, 32'hFFFF_0000);
        send_beat(OP_DRAW, 32'h0000_FFFF);
        send_beat(OP_RESEED, 32'h7FFF_FFFF);
        send_beat(OP_DRAW, 32'h8000_0000);
        send_beat(OP_DRAW, 32'h7FFF_FFFF);

        // Random phases: no idling, sender idle, receiver stalling, both.
        send_idle_pct = 0;  recv_stall_pct = 0;
        send_random_beats(PHASE_BEATS);
        send_idle_pct = 86; recv_stall_pct = 0;
        send_random_beats(PHASE_BEATS);
        send_idle_pct = 0;  recv_stall_pct = 86;
        send_random_beats(PHASE_BEATS);
        send_idle_pct = 17; recv_stall_pct = 17;
        send_random_beats(PHASE_BEATS);

        // Back-pressure: hold the receiver off while the sender keeps offering,
        // so the output register fills and s_tready drops.
        send_idle_pct = 0;  recv_stall_pct = 0;
        hold_request  = 1'b1;
        send_random_beats(30);

        // Drain: stop offering, let every awaited draw arrive, then settle.
        s_tvalid      <= 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        while (draws_outstanding != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && draws_outstanding == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/xs128_pkg.sv
rtl/core/xs128_ctrl.sv
rtl/core/xs128_datapath.sv
rtl/core/xorshift128_generator_top.sv
tb/xorshift128_draw_checker.sv
tb/xorshift128_generator_top_tb.sv
